// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, expr) \
  `ASSERT_CLK(lbl, !(expr))

`else

`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)

`endif

`endif

// File: rtl/ieas_pkg.sv
// ----------------------------------------------------------------------------
// ieas_pkg
// shared types and codes of the i2c eeprom access sequencer
// ----------------------------------------------------------------------------
package ieas_pkg;

  localparam int ADDR_MAX_W = 11;
  localparam int TMO_REG_W  = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  localparam logic [TMO_REG_W-1:0] TMO_RESET  = 16'd2000;
  localparam logic [7:0]           BASE_RESET = 8'hA0;
  localparam logic [7:0]           BASE_MASK  = 8'hFE;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVBASE = 1'd1;

  localparam logic [1:0] FUNC_RD   = 2'd0;
  localparam logic [1:0] FUNC_WR   = 2'd1;
  localparam logic [1:0] FUNC_SNAP = 2'd2;
  localparam logic [1:0] FUNC_TICK = 2'd3;

  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_START     = 3'd1;
  localparam logic [2:0] ACT_START_ACK = 3'd2;
  localparam logic [2:0] ACT_SEND      = 3'd3;
  localparam logic [2:0] ACT_STOP      = 3'd4;
  localparam logic [2:0] ACT_STOP_CLR  = 3'd5;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_TIMEOUT = 2'd1;
  localparam logic [1:0] STAT_ERR     = 2'd2;

  typedef struct packed {
    logic busy;
    logic start_sent;
    logic addr_sent;
    logic tx_empty;
    logic byte_finished;
    logic rx_ready;
  } eng_flags_t;

  typedef struct packed {
    logic                  is_req;
    logic                  is_wr;
    logic                  is_snap;
    logic                  is_tick;
    logic [ADDR_MAX_W-1:0] mem_addr;
    logic [7:0]            wr_data;
    logic [7:0]            rx_byte;
    eng_flags_t            flags;
    logic                  err_any;
  } item_t;

endpackage

// File: rtl/ieas_front.sv
// ----------------------------------------------------------------------------
// ieas_front
// accepts requests, snapshots and ticks, decodes them and queues them
// ----------------------------------------------------------------------------
module ieas_front #(
  parameter int ADDR_BITS = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_func,
  input  logic [ADDR_BITS-1:0]   in_mem_addr,
  input  logic [7:0]             in_wr_data,
  input  logic [7:0]             in_rx_byte,
  input  logic                   in_flag_busy,
  input  logic                   in_flag_start_sent,
  input  logic                   in_flag_addr_sent,
  input  logic                   in_flag_tx_empty,
  input  logic                   in_flag_byte_finished,
  input  logic                   in_flag_rx_ready,
  input  logic [2:0]             in_err_flags,
  output logic                   head_valid,
  output ieas_pkg::item_t        head_item,
  input  logic                   head_pop
);

  ieas_pkg::item_t                  q_mem_r [ieas_pkg::QDEPTH];
  logic [ieas_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [ieas_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [ieas_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  ieas_pkg::item_t                  dec;
  logic                             push;
  logic                             pop;

  // decode
  always_comb begin
    dec.is_req     = (in_func == ieas_pkg::FUNC_RD) || (in_func == ieas_pkg::FUNC_WR);
    dec.is_wr      = (in_func == ieas_pkg::FUNC_WR);
    dec.is_snap    = (in_func == ieas_pkg::FUNC_SNAP);
    dec.is_tick    = (in_func == ieas_pkg::FUNC_TICK);
    dec.mem_addr   = ieas_pkg::ADDR_MAX_W'(in_mem_addr);
    dec.wr_data    = in_wr_data;
    dec.rx_byte    = in_rx_byte;
    dec.flags.busy          = in_flag_busy;
    dec.flags.start_sent    = in_flag_start_sent;
    dec.flags.addr_sent     = in_flag_addr_sent;
    dec.flags.tx_empty      = in_flag_tx_empty;
    dec.flags.byte_finished = in_flag_byte_finished;
    dec.flags.rx_ready      = in_flag_rx_ready;
    dec.err_any    = |in_err_flags;
  end

  assign in_stall   = (cnt_r == ieas_pkg::QCNT_W'(ieas_pkg::QDEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (cnt_r != '0);
  assign pop        = head_pop && head_valid;
  assign head_item  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// File: rtl/ieas_back.sv
// ----------------------------------------------------------------------------
// ieas_back
// transaction state machine, configuration registers and output register
// ----------------------------------------------------------------------------
module ieas_back #(
  parameter int ADDR_BITS     = 11,
  parameter int TIMEOUT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [ieas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ieas_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              head_valid,
  input  ieas_pkg::item_t                   head_item,
  output logic                              head_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_action,
  output logic [7:0]                        out_tx_byte,
  output logic                              out_done_res,
  output logic [1:0]                        out_status,
  output logic [7:0]                        out_rd_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_BUSY  = 4'd1;
  localparam logic [3:0] ST_SB1   = 4'd2;
  localparam logic [3:0] ST_ADDR1 = 4'd3;
  localparam logic [3:0] ST_TXE   = 4'd4;
  localparam logic [3:0] ST_BTF   = 4'd5;
  localparam logic [3:0] ST_SB2   = 4'd6;
  localparam logic [3:0] ST_ADDR2 = 4'd7;
  localparam logic [3:0] ST_RXNE  = 4'd8;

  localparam int CMP_W = (TIMEOUT_WIDTH > ieas_pkg::TMO_REG_W) ?
                         TIMEOUT_WIDTH : ieas_pkg::TMO_REG_W;
  localparam logic [TIMEOUT_WIDTH-1:0] CNT_MAX = {TIMEOUT_WIDTH{1'b1}};

  logic [ieas_pkg::TMO_REG_W-1:0] tmo_r;
  logic [7:0]                     base_r;

  logic [3:0]                step_r, step_nxt;
  logic [TIMEOUT_WIDTH-1:0]  cnt_r, cnt_nxt;
  logic                      is_wr_r, is_wr_nxt;
  logic [ADDR_BITS-1:0]      addr_r, addr_nxt;
  logic [7:0]                data_r, data_nxt;
  logic                      bidx_r, bidx_nxt;

  logic                      out_valid_r;
  logic [2:0]                out_action_r;
  logic [7:0]                out_tx_byte_r;
  logic                      out_done_r;
  logic [1:0]                out_status_r;
  logic [7:0]                out_rd_data_r;

  logic [2:0]                act;
  logic [7:0]                txb;
  logic                      done;
  logic [1:0]                stat;
  logic [7:0]                rdd;
  logic [TIMEOUT_WIDTH-1:0]  cnt_inc;
  logic                      err_watch;
  logic [7:0]                page;

  assign head_pop = head_valid && (!out_valid_r || !out_stall);
  assign page     = 8'(addr_r >> 8);

  function automatic logic [7:0] dev_byte(input logic [7:0] base,
                                          input logic [7:0] pg,
                                          input logic       rd);
    logic [7:0] sum;
    sum = (base & ieas_pkg::BASE_MASK) + (pg << 1);
    return sum | {7'd0, rd};
  endfunction

  always_comb begin
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    is_wr_nxt = is_wr_r;
    addr_nxt  = addr_r;
    data_nxt  = data_r;
    bidx_nxt  = bidx_r;
    act       = ieas_pkg::ACT_NONE;
    txb       = 8'd0;
    done      = 1'b0;
    stat      = ieas_pkg::STAT_OK;
    rdd       = 8'd0;
    cnt_inc   = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
    err_watch = step_r inside {ST_ADDR1, ST_TXE, ST_ADDR2, ST_RXNE};

    if (step_r == ST_IDLE) begin
      if (head_item.is_req) begin
        is_wr_nxt = head_item.is_wr;
        addr_nxt  = ADDR_BITS'(head_item.mem_addr);
        data_nxt  = head_item.wr_data;
        bidx_nxt  = 1'b0;
        step_nxt  = ST_BUSY;
        cnt_nxt   = '0;
      end
    end else if (step_r > ST_RXNE) begin
      step_nxt = ST_IDLE;
    end else if (head_item.is_tick) begin
      cnt_nxt = cnt_inc;
      if ((CMP_W'(cnt_inc) >= CMP_W'(tmo_r)) || (cnt_inc == CNT_MAX)) begin
        done     = 1'b1;
        stat     = ieas_pkg::STAT_TIMEOUT;
        step_nxt = ST_IDLE;
      end
    end else if (head_item.is_snap) begin
      if (err_watch && head_item.err_any) begin
        act      = ieas_pkg::ACT_STOP_CLR;
        done     = 1'b1;
        stat     = ieas_pkg::STAT_ERR;
        step_nxt = ST_IDLE;
      end else begin
        case (step_r)
          ST_BUSY: begin
            if (!head_item.flags.busy) begin
              act      = ieas_pkg::ACT_START;
              step_nxt = ST_SB1;
              cnt_nxt  = '0;
            end
          end
          ST_SB1: begin
            if (head_item.flags.start_sent) begin
              act      = ieas_pkg::ACT_SEND;
              txb      = dev_byte(base_r, page, 1'b0);
              step_nxt = ST_ADDR1;
              cnt_nxt  = '0;
            end
          end
          ST_ADDR1: begin
            if (head_item.flags.addr_sent) begin
              bidx_nxt = 1'b0;
              step_nxt = ST_TXE;
              cnt_nxt  = '0;
            end
          end
          ST_TXE: begin
            if (head_item.flags.tx_empty) begin
              act     = ieas_pkg::ACT_SEND;
              cnt_nxt = '0;
              if (!bidx_r) begin
                txb = addr_r[7:0];
                if (is_wr_r) begin
                  bidx_nxt = 1'b1;
                  step_nxt = ST_TXE;
                end else begin
                  step_nxt = ST_BTF;
                end
              end else begin
                txb      = data_r;
                step_nxt = ST_BTF;
              end
            end
          end
          ST_BTF: begin
            if (head_item.flags.tx_empty && head_item.flags.byte_finished) begin
              if (is_wr_r) begin
                act      = ieas_pkg::ACT_STOP;
                done     = 1'b1;
                step_nxt = ST_IDLE;
              end else begin
                act      = ieas_pkg::ACT_START_ACK;
                step_nxt = ST_SB2;
                cnt_nxt  = '0;
              end
            end
          end
          ST_SB2: begin
            if (head_item.flags.start_sent) begin
              act      = ieas_pkg::ACT_SEND;
              txb      = dev_byte(base_r, page, 1'b1);
              step_nxt = ST_ADDR2;
              cnt_nxt  = '0;
            end
          end
          ST_ADDR2: begin
            if (head_item.flags.addr_sent) begin
              act      = ieas_pkg::ACT_STOP;
              step_nxt = ST_RXNE;
              cnt_nxt  = '0;
            end
          end
          default: begin
            if (head_item.flags.rx_ready) begin
              done     = 1'b1;
              rdd      = head_item.rx_byte;
              step_nxt = ST_IDLE;
            end
          end
        endcase
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r  <= ieas_pkg::TMO_RESET;
      base_r <= ieas_pkg::BASE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ieas_pkg::CFG_TIMEOUT: tmo_r  <= cfg_wdata;
        ieas_pkg::CFG_DEVBASE: base_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_IDLE;
      cnt_r   <= '0;
      is_wr_r <= 1'b0;
      addr_r  <= '0;
      data_r  <= '0;
      bidx_r  <= 1'b0;
    end else if (head_pop) begin
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      is_wr_r <= is_wr_nxt;
      addr_r  <= addr_nxt;
      data_r  <= data_nxt;
      bidx_r  <= bidx_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (head_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      out_action_r  <= act;
      out_tx_byte_r <= txb;
      out_done_r    <= done;
      out_status_r  <= stat;
      out_rd_data_r <= rdd;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_action   = out_action_r;
  assign out_tx_byte  = out_tx_byte_r;
  assign out_done_res = out_done_r;
  assign out_status   = out_status_r;
  assign out_rd_data  = out_rd_data_r;

endmodule

// File: rtl/i2c_eeprom_access_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_access_sequencer
// single-byte write and random read of a serial eeprom via a byte-level
// i2c master engine, at most one engine command per input item
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries read or write requests,
//   engine status snapshots and time ticks; each accepted item gives exactly
//   one result on the output channel (out_valid / out_stall): an engine
//   command, its byte, and done / status / read data at transaction end.
//   items enter a four-entry queue; the back end takes one item per cycle
//   into the output register while out_stall is low, so an accepted item is
//   held in a queue entry and then in the output register that drives out_valid.
//   when out_stall is high the result holds, the queue fills and in_stall
//   rises once four items are waiting.
//   cfg_valid / cfg_ready write timeout_ticks (index 0) and device_base
//   (index 1); cfg_ready is always high, write only while the block is idle.
//   reset (rst_n low, synchronous) empties the queue, drops out_valid,
//   returns the sequencer to idle and loads 2000 ticks and base 0xa0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_eeprom_access_sequencer #(
  parameter int ADDR_BITS     = 11,
  parameter int TIMEOUT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ieas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ieas_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_func,
  input  logic [ADDR_BITS-1:0]              in_mem_addr,
  input  logic [7:0]                        in_wr_data,
  input  logic [7:0]                        in_rx_byte,
  input  logic                              in_flag_busy,
  input  logic                              in_flag_start_sent,
  input  logic                              in_flag_addr_sent,
  input  logic                              in_flag_tx_empty,
  input  logic                              in_flag_byte_finished,
  input  logic                              in_flag_rx_ready,
  input  logic [2:0]                        in_err_flags,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_action,
  output logic [7:0]                        out_tx_byte,
  output logic                              out_done_res,
  output logic [1:0]                        out_status,
  output logic [7:0]                        out_rd_data
);

  logic            head_valid;
  logic            head_pop;
  ieas_pkg::item_t head_item;

  assign cfg_ready = 1'b1;

  ieas_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_func               (in_func),
    .in_mem_addr           (in_mem_addr),
    .in_wr_data            (in_wr_data),
    .in_rx_byte            (in_rx_byte),
    .in_flag_busy          (in_flag_busy),
    .in_flag_start_sent    (in_flag_start_sent),
    .in_flag_addr_sent     (in_flag_addr_sent),
    .in_flag_tx_empty      (in_flag_tx_empty),
    .in_flag_byte_finished (in_flag_byte_finished),
    .in_flag_rx_ready      (in_flag_rx_ready),
    .in_err_flags          (in_err_flags),
    .head_valid            (head_valid),
    .head_item             (head_item),
    .head_pop              (head_pop)
  );

  ieas_back #(
    .ADDR_BITS     (ADDR_BITS),
    .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .head_pop     (head_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_action   (out_action),
    .out_tx_byte  (out_tx_byte),
    .out_done_res (out_done_res),
    .out_status   (out_status),
    .out_rd_data  (out_rd_data)
  );

  // status and read data only accompany a finished transaction
  `ASSERT_CLK(a_status_with_done,
    out_valid && !out_done_res |-> out_status == ieas_pkg::STAT_OK && out_rd_data == 8'd0)
  // an error abort always issues stop-and-clear
  `ASSERT_CLK(a_err_stop_clr,
    out_valid && out_status == ieas_pkg::STAT_ERR |-> out_action == ieas_pkg::ACT_STOP_CLR)
  // a byte is only driven with a send command
  `ASSERT_NEVER(a_txb_only_send,
    out_valid && out_tx_byte != 8'd0 && out_action != ieas_pkg::ACT_SEND)
  // the queue never pops while empty
  `ASSERT_NEVER(a_pop_empty, head_pop && !head_valid)

endmodule
